// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file gdsa_checker.sv.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define GDSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define GDSA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/gdsa_pkg.sv -----
// Shared types, codes and fp32 arithmetic helpers for the GEMV dot engine.
// No dependencies.
package gdsa_pkg;

  localparam int GDSA_QUEUE_DEPTH = 8;

  // number_format codes
  localparam logic [2:0] FMT_FP16      = 3'd0;
  localparam logic [2:0] FMT_FP32      = 3'd1;
  localparam logic [2:0] FMT_FP16_WIDE = 3'd2;
  localparam logic [2:0] FMT_BF16      = 3'd3;
  localparam logic [2:0] FMT_BF16_WIDE = 3'd4;

  // register indexes
  localparam logic [1:0] REG_NUMBER_FORMAT = 2'd0;
  localparam logic [1:0] REG_ALPHA         = 2'd1;
  localparam logic [1:0] REG_BETA          = 2'd2;

  localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;

  // raw product ahead of rounding: value = mant * 2^(exp - 127 - 46)
  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               sign;
    logic signed [11:0] exp;
    logic [47:0]        mant;
  } mraw_t;

  // one request between front and back
  typedef struct packed {
    logic [31:0] prod;
    logic [31:0] old_y;
    logic        last;
  } gdsa_item_t;

  function automatic logic [2:0] fmt_eff(input logic [2:0] f);
    return (f > FMT_BF16_WIDE) ? FMT_BF16_WIDE : f;
  endfunction

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  k;
    logic        hit;
    logic [9:0]  mn;
    logic [31:0] res;
    ex  = h[14:10];
    man = h[9:0];
    k   = 4'd0;
    hit = 1'b0;
    mn  = man;
    if (ex == 5'h1F) begin
      res = {h[15], 8'hFF, man, 13'b0};
    end else if (ex == 5'h00) begin
      if (man == 10'd0) begin
        res = {h[15], 31'b0};
      end else begin
        for (int i = 9; i >= 0; i--) begin
          if (!hit && man[i]) begin
            k   = 4'(10 - i);
            hit = 1'b1;
          end
        end
        mn  = man << k;
        res = {h[15], 8'(8'd113 - {4'b0, k}), mn, 13'b0};
      end
    end else begin
      res = {h[15], 8'({3'b0, ex} + 8'd112), man, 13'b0};
    end
    return res;
  endfunction

  function automatic logic [31:0] widen_in(input logic [2:0] f, input logic [31:0] v);
    logic [31:0] res;
    unique case (f) inside
      FMT_FP32:                res = v;
      FMT_FP16, FMT_FP16_WIDE: res = half_to_single(v[15:0]);
      default:                 res = {v[15:0], 16'b0};
    endcase
    return res;
  endfunction

  function automatic logic [31:0] widen_old_y(input logic [2:0] f, input logic [31:0] v);
    logic [31:0] res;
    unique case (f)
      FMT_FP16: res = half_to_single(v[15:0]);
      FMT_BF16: res = {v[15:0], 16'b0};
      default:  res = v;
    endcase
    return res;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] m);
    logic [5:0] n;
    logic       hit;
    n   = 6'd48;
    hit = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!hit && m[i]) begin
        n   = 6'(47 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Normalise, round to nearest even and pack; value = m * 2^(e - 127 - 46).
  function automatic logic [31:0] round_pack(input logic sign, input logic signed [11:0] e,
                                             input logic [47:0] m, input logic sticky);
    logic [5:0]         lz;
    logic signed [11:0] be;
    logic [11:0]        sh;
    logic [47:0]        mn;
    logic [47:0]        s;
    logic [47:0]        mask;
    logic               st;
    logic               inc;
    logic [7:0]         expf;
    logic [30:0]        body;
    logic [31:0]        res;
    lz   = lzc48(m);
    be   = e + 12'sd1 - $signed({6'b0, lz});
    mn   = m << lz;
    s    = mn;
    st   = sticky;
    expf = be[7:0];
    sh   = 12'(12'sd1 - be);
    mask = 48'd0;
    if (m == 48'd0) begin
      res = {sign, 31'b0};
    end else if (be >= 12'sd255) begin
      res = {sign, 8'hFF, 23'b0};
    end else begin
      if (be <= 12'sd0) begin
        expf = 8'd0;
        if (sh >= 12'd48) begin
          s  = 48'd0;
          st = st | (|mn);
        end else begin
          mask = (48'd1 << sh) - 48'd1;
          s    = mn >> sh;
          st   = st | (|(mn & mask));
        end
      end
      st   = st | (|s[22:0]);
      inc  = s[23] & (st | s[24]);
      body = {expf, s[46:24]} + 31'(inc);
      res  = {sign, body};
    end
    return res;
  endfunction

  function automatic mraw_t mul_raw(input logic [31:0] a, input logic [31:0] b);
    mraw_t      r;
    logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0] ea, eb;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    r.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    r.inf  = a_inf | b_inf;
    r.sign = a[31] ^ b[31];
    r.exp  = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd127;
    r.mant = {a[30:23] != 8'd0, a[22:0]} * {b[30:23] != 8'd0, b[22:0]};
    return r;
  endfunction

  function automatic logic [31:0] mul_finish(input mraw_t r);
    logic [31:0] res;
    if (r.nan)      res = FP32_QNAN;
    else if (r.inf) res = {r.sign, 8'hFF, 23'b0};
    else            res = round_pack(r.sign, r.exp, r.mant, 1'b0);
    return res;
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [31:0] x, y;
    logic [7:0]  ex, ey, d;
    logic [47:0] ax, by, bs, mask, m;
    logic        stk, zs;
    logic [31:0] res;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex   = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d    = ex - ey;
    ax   = {1'b0, x[30:23] != 8'd0, x[22:0], 23'b0};
    by   = {1'b0, y[30:23] != 8'd0, y[22:0], 23'b0};
    mask = 48'd0;
    if (d >= 8'd48) begin
      bs  = 48'd0;
      stk = |by;
    end else begin
      mask = (48'd1 << d) - 48'd1;
      bs   = by >> d;
      stk  = |(by & mask);
    end
    // jam lost bits into the lsb so subtraction still rounds right
    bs = bs | {47'd0, stk};
    m  = (x[31] ^ y[31]) ? (ax - bs) : (ax + bs);
    zs = (m == 48'd0) ? (x[31] & y[31]) : x[31];
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) res = FP32_QNAN;
    else if (a_inf) res = a;
    else if (b_inf) res = b;
    else            res = round_pack(zs, $signed({4'b0, ex}), m, 1'b0);
    return res;
  endfunction

  function automatic logic [15:0] to_half(input logic [31:0] f);
    logic [15:0]       sgn;
    logic [7:0]        ex;
    logic [22:0]       man;
    logic [23:0]       m, rem, halfp;
    logic [15:0]       h;
    logic [4:0]        s;
    logic signed [9:0] e;
    logic [15:0]       res;
    sgn   = {f[31], 15'b0};
    ex    = f[30:23];
    man   = f[22:0];
    m     = {1'b1, man};
    e     = $signed({2'b0, ex}) - 10'sd127;
    h     = 16'd0;
    rem   = 24'd0;
    halfp = 24'd0;
    s     = 5'd0;
    if (ex == 8'hFF) begin
      res = (man != 23'd0) ? 16'h7E00 : (sgn | 16'h7BFF);
    end else if (ex == 8'd0) begin
      res = sgn;
    end else if (e > 10'sd15) begin
      res = sgn | 16'h7BFF;
    end else if (e >= -10'sd14) begin
      h   = {1'b0, 5'(e + 10'sd15), m[22:13]};
      rem = {11'b0, m[12:0]};
      if (rem > 24'h1000 || (rem == 24'h1000 && h[0])) h = h + 16'd1;
      if (h >= 16'h7C00) h = 16'h7BFF;
      res = sgn | h;
    end else if (e < -10'sd25) begin
      res = sgn;
    end else begin
      s     = 5'(-e - 10'sd1);
      h     = 16'(m >> s);
      rem   = m & ((24'd1 << s) - 24'd1);
      halfp = 24'd1 << (s - 5'd1);
      if (rem > halfp || (rem == halfp && h[0])) h = h + 16'd1;
      res = sgn | h;
    end
    return res;
  endfunction

  function automatic logic [15:0] to_bf16(input logic [31:0] f);
    logic [15:0] h, rem, res;
    h   = {1'b0, f[30:16]};
    rem = f[15:0];
    if (f[30:23] == 8'hFF) begin
      res = (f[22:0] != 23'd0) ? 16'h7FC0 : {f[31], 15'h7F7F};
    end else begin
      if (rem > 16'h8000 || (rem == 16'h8000 && h[0])) h = h + 16'd1;
      if (h >= 16'h7F80) h = 16'h7F7F;
      res = {f[31], 15'b0} | h;
    end
    return res;
  endfunction

endpackage

// ----- hdl/gdsa_fifo.sv -----
// Request queue between the front (products) and the back (accumulation).
// Depends on gdsa_pkg for the request type.
module gdsa_fifo import gdsa_pkg::*; #(
  parameter int DEPTH = GDSA_QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gdsa_item_t        wdata,
  input  logic              pop,
  output gdsa_item_t        rdata,
  output logic              empty,
  output logic [LW-1:0]     level
);

  gdsa_item_t          mem_r [DEPTH];
  logic [PW-1:0]       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [LW-1:0]       level_r, level_nxt;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    level_nxt = level_r;
    if (push) wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    if (pop)  rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    if (push && !pop)      level_nxt = level_r + LW'(1);
    else if (pop && !push) level_nxt = level_r - LW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      level_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

  assign rdata = mem_r[rptr_r];
  assign empty = (level_r == '0);
  assign level = level_r;

endmodule

// ----- hdl/gdsa_front.sv -----
// Front end: accepts elements, widens them to fp32 and forms the rounded product.
// Depends on gdsa_pkg; feeds gdsa_fifo.
module gdsa_front import gdsa_pkg::*; #(
  parameter int DEPTH = GDSA_QUEUE_DEPTH,
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [2:0]    fmt,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [31:0]   in_matrix_bits,
  input  logic [31:0]   in_vector_bits,
  input  logic [31:0]   in_old_y_bits,
  input  logic          in_end_of_dot,
  input  logic [LW-1:0] level,
  output logic          push,
  output gdsa_item_t    push_item
);

  logic        a_v_r, m_v_r;
  logic [31:0] a_mat_r, a_vec_r, a_oy_r, m_oy_r;
  logic        a_last_r, m_last_r;
  mraw_t       m_raw_r;
  logic [2:0]  fe;
  logic        accept;
  logic [LW:0] booked;

  assign fe = fmt_eff(fmt);

  // every accepted request already owns a queue slot
  assign booked   = {1'b0, level} + (LW+1)'(a_v_r) + (LW+1)'(m_v_r);
  assign in_stall = (booked >= (LW+1)'(DEPTH));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      m_v_r <= 1'b0;
    end else begin
      a_v_r <= accept;
      m_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_mat_r  <= widen_in(fe, in_matrix_bits);
      a_vec_r  <= widen_in(fe, in_vector_bits);
      a_oy_r   <= widen_old_y(fe, in_old_y_bits);
      a_last_r <= in_end_of_dot;
    end
    m_raw_r  <= mul_raw(a_mat_r, a_vec_r);
    m_oy_r   <= a_oy_r;
    m_last_r <= a_last_r;
  end

  assign push           = m_v_r;
  assign push_item.prod  = mul_finish(m_raw_r);
  assign push_item.old_y = m_oy_r;
  assign push_item.last  = m_last_r;

endmodule

// ----- hdl/gdsa_back.sv -----
// Back end: accumulates products, then scales, sums and, for fp16 and bf16, narrows on the last one.
// Depends on gdsa_pkg; drains gdsa_fifo.
module gdsa_back import gdsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  fmt,
  input  logic [31:0] alpha,
  input  logic [31:0] beta,
  input  gdsa_item_t  item,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_y_bits
);

  logic [31:0] acc_r, acc_nxt, sum;
  logic        b1_v_r, b2_v_r, b3_v_r, b4_v_r, out_valid_r;
  logic [31:0] b1_acc_r, b1_oy_r;
  mraw_t       b2_ma_r, b2_mb_r;
  logic [31:0] b3_sa_r, b3_sb_r, b4_res_r, out_y_r;
  logic [31:0] y_nxt;
  logic [2:0]  fe;
  logic        adv;

  assign fe  = fmt_eff(fmt);
  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && !empty;
  assign sum = fadd(acc_r, item.prod);

  always_comb begin
    acc_nxt = acc_r;
    if (pop) acc_nxt = item.last ? 32'd0 : sum;
  end

  always_comb begin
    unique case (fe)
      FMT_FP16: y_nxt = {16'b0, to_half(b4_res_r)};
      FMT_BF16: y_nxt = {16'b0, to_bf16(b4_res_r)};
      default:  y_nxt = ((b4_res_r[30:23] == 8'hFF) && (b4_res_r[22:0] != 23'd0))
                        ? FP32_QNAN : b4_res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 32'd0;
      b1_v_r      <= 1'b0;
      b2_v_r      <= 1'b0;
      b3_v_r      <= 1'b0;
      b4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      acc_r       <= acc_nxt;
      b1_v_r      <= pop && item.last;
      b2_v_r      <= b1_v_r;
      b3_v_r      <= b2_v_r;
      b4_v_r      <= b3_v_r;
      out_valid_r <= b4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_acc_r <= sum;
      b1_oy_r  <= item.old_y;
      b2_ma_r  <= mul_raw(alpha, b1_acc_r);
      b2_mb_r  <= mul_raw(beta, b1_oy_r);
      b3_sa_r  <= mul_finish(b2_ma_r);
      b3_sb_r  <= mul_finish(b2_mb_r);
      b4_res_r <= fadd(b3_sa_r, b3_sb_r);
      out_y_r  <= y_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_y_bits = out_y_r;

endmodule

// ----- hdl/gemv_dot_scale_accumulate.sv -----
// Top level of the GEMV dot engine: register file, front, queue and back.
// Depends on gdsa_pkg, gdsa_front, gdsa_fifo and gdsa_back.
//
//  port group | direction | handshake          | payload
//  in_*       | in        | in_valid/in_stall  | matrix, vector, old y, end_of_dot
//  out_*      | out       | out_valid/out_stall| y_bits
//  APB        | in/out    | psel/penable/pready| paddr, pwdata, prdata
//
// One element accepted per cycle while in_stall is low; the combinational fp32 accumulate
// adder closes that loop. Results pass front a, m, the queue, back b1 to b4 and out_y.
// Reset clears the accumulator, the queue and all valid flags; no clearing pass.
// An output stall holds the back end; the queue then fills and in_stall rises.
module gemv_dot_scale_accumulate import gdsa_pkg::*; #(
  parameter int QUEUE_DEPTH = GDSA_QUEUE_DEPTH,
  localparam int LW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_matrix_bits,
  input  logic [31:0] in_vector_bits,
  input  logic [31:0] in_old_y_bits,
  input  logic        in_end_of_dot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_y_bits
);

  logic [2:0]    fmt_r;
  logic [31:0]   alpha_r, beta_r;
  logic          wr_en;
  logic          push, pop, empty;
  gdsa_item_t    push_item, head;
  logic [LW-1:0] level;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_FP32;
      alpha_r <= 32'h3F80_0000;
      beta_r  <= 32'd0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_NUMBER_FORMAT: fmt_r   <= pwdata[2:0];
        REG_ALPHA:         alpha_r <= pwdata;
        REG_BETA:          beta_r  <= pwdata;
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NUMBER_FORMAT: prdata = {29'b0, fmt_r};
      REG_ALPHA:         prdata = alpha_r;
      REG_BETA:          prdata = beta_r;
      default:           prdata = 32'd0;
    endcase
  end

  gdsa_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .fmt            (fmt_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_matrix_bits (in_matrix_bits),
    .in_vector_bits (in_vector_bits),
    .in_old_y_bits  (in_old_y_bits),
    .in_end_of_dot  (in_end_of_dot),
    .level          (level),
    .push           (push),
    .push_item      (push_item)
  );

  gdsa_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_item),
    .pop   (pop),
    .rdata (head),
    .empty (empty),
    .level (level)
  );

  gdsa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fmt        (fmt_r),
    .alpha      (alpha_r),
    .beta       (beta_r),
    .item       (head),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_y_bits (out_y_bits)
  );

endmodule

// ----- hdl/gdsa_checker.sv -----
// Port-level checks for the GEMV dot engine, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module gdsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_y_bits
);

  `GDSA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")
  `GDSA_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_y_bits), "stalled result changed")
  `GDSA_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "result valid straight after reset")
  `GDSA_ASSERT_RST(a_rst_in, !rst_n |=> !in_stall, "input stalled straight after reset")

endmodule

bind gemv_dot_scale_accumulate gdsa_checker u_gdsa_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for gemv_dot_scale_accumulate: stimulus, fp32 predictor and result check.
// Depends on gdsa_pkg for format codes, register indexes and the quiet NaN; needs only the RTL.
module testbench;
  import gdsa_pkg::*;

  typedef struct {
    logic [31:0] m;
    logic [31:0] v;
    logic [31:0] oy;
    logic        eod;
    logic        known;
    logic [31:0] y;
  } dot_row_t;

  typedef struct {
    logic [31:0] y;
    logic        known;
    logic [31:0] y_typed;
  } y_pred_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_matrix_bits = '0, in_vector_bits = '0, in_old_y_bits = '0;
  logic        in_end_of_dot = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_y_bits;

  // predictor state
  logic [2:0]  cur_fmt = FMT_FP32;
  logic [31:0] cur_alpha = 32'h3F80_0000;
  logic [31:0] cur_beta = 32'h0;
  logic [31:0] dot_acc = 32'h0;
  y_pred_t     y_pending[$];
  int unsigned requests_taken = 0;
  int unsigned mismatches = 0;
  bit          long_hold_req = 0;
  bit          pending_known = 0;
  logic [31:0] pending_typed = '0;

  gemv_dot_scale_accumulate dut (.*);

  always #4 clk = ~clk;

  initial begin
    #(8 * 1_500_000);
    $display("gemv_dot_scale_accumulate test failed");
    $finish;
  end

  // ---------------- fp32 arithmetic ----------------

  function automatic void fp_split(input logic [31:0] a, output logic [127:0] m,
                                   output int e);
    if (a[30:23] == 8'd0) begin
      m = {105'd0, a[22:0]};
      e = -149;
    end else begin
      m = {104'd0, 1'b1, a[22:0]};
      e = int'(a[30:23]) - 150;
    end
  endfunction

  // round m * 2^e to fp32, nearest even
  function automatic logic [31:0] fp_pack(input logic s, input logic [127:0] m, input int e);
    int          p, sh;
    logic [127:0] r, rem, halfp;
    longint      bits;
    if (m == 0) return {s, 31'b0};
    p = 127;
    while (!m[p]) p--;
    sh = p - 23;
    if (sh < -149 - e) sh = -149 - e;
    if (sh > p + 1) begin
      // below half the smallest step: rounds to zero
      r = '0;
    end else if (sh > 0) begin
      r     = m >> sh;
      rem   = m & ((128'd1 << sh) - 128'd1);
      halfp = 128'd1 << (sh - 1);
      if (rem > halfp || (rem == halfp && r[0])) r = r + 1;
    end else begin
      r = m << (-sh);
    end
    bits = (longint'(e + sh + 149) <<< 23) + longint'(r[31:0]);
    if (bits >= 64'h7F80_0000) return {s, 8'hFF, 23'b0};
    return {s, bits[30:0]};
  endfunction

  function automatic bit is_nan(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != 0;
  endfunction

  function automatic bit is_inf(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] == 0;
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma, mb;
    int           ea, eb;
    if (is_nan(a) || is_nan(b) || (is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0))
      return FP32_QNAN;
    if (is_inf(a) || is_inf(b)) return {a[31] ^ b[31], 8'hFF, 23'b0};
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    return fp_pack(a[31] ^ b[31], ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]  x, y;
    logic [127:0] mx, my, sum;
    int           ex, ey, d, es;
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31])) return FP32_QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (b[30:0] > a[30:0]) begin
      x = b; y = a;
    end else begin
      x = a; y = b;
    end
    fp_split(x, mx, ex);
    fp_split(y, my, ey);
    d = ex - ey;
    if (d > 60) begin
      // far smaller operand only nudges the sticky position
      sum = mx << 3;
      es  = ex - 3;
      if (my != 0) sum = (x[31] ^ y[31]) ? sum - 1 : sum + 1;
    end else begin
      sum = (x[31] ^ y[31]) ? (mx << d) - my : (mx << d) + my;
      es  = ey;
    end
    if (sum == 0) return {x[31] & y[31], 31'b0};
    return fp_pack(x[31], sum, es);
  endfunction

  function automatic logic [31:0] h16_to_fp32(input logic [15:0] h);
    logic [127:0] m;
    int           e;
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'b0};
    if (h[14:10] == 5'd0) begin
      m = {118'd0, h[9:0]};
      e = -24;
    end else begin
      m = {117'd0, 1'b1, h[9:0]};
      e = int'(h[14:10]) - 25;
    end
    return fp_pack(h[15], m, e);
  endfunction

  function automatic logic [15:0] fp32_to_h16(input logic [31:0] f);
    logic [15:0] sgn;
    logic [31:0] m, h, rem, halfp;
    int          e, s;
    sgn = {f[31], 15'b0};
    if (f[30:23] == 8'hFF) return (f[22:0] != 0) ? 16'h7E00 : (sgn | 16'h7BFF);
    if (f[30:23] == 8'd0) return sgn;
    e = int'(f[30:23]) - 127;
    if (e > 15) return sgn | 16'h7BFF;
    m = {8'd0, 1'b1, f[22:0]};
    if (e >= -14) begin
      h   = (32'(e + 15) << 10) | ((m >> 13) & 32'h3FF);
      rem = m & 32'h1FFF;
      if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h = h + 1;
      if (h >= 32'h7C00) h = 32'h7BFF;
      return sgn | h[15:0];
    end
    s = -e - 1;
    if (s > 24) return sgn;
    h     = m >> s;
    rem   = m & ((32'd1 << s) - 1);
    halfp = 32'd1 << (s - 1);
    if (rem > halfp || (rem == halfp && h[0])) h = h + 1;
    return sgn | h[15:0];
  endfunction

  function automatic logic [15:0] fp32_to_bf16(input logic [31:0] f);
    logic [15:0] h;
    if (f[30:23] == 8'hFF) return (f[22:0] != 0) ? 16'h7FC0 : {f[31], 15'h7F7F};
    h = {1'b0, f[30:16]};
    if (f[15:0] > 16'h8000 || (f[15:0] == 16'h8000 && h[0])) h = h + 1;
    if (h >= 16'h7F80) h = 16'h7F7F;
    return {f[31], 15'b0} | h;
  endfunction

  function automatic logic [31:0] widen_element(input logic [2:0] f, input logic [31:0] v);
    case (f)
      FMT_FP32:                return v;
      FMT_FP16, FMT_FP16_WIDE: return h16_to_fp32(v[15:0]);
      default:                 return {v[15:0], 16'b0};
    endcase
  endfunction

  // ---------------- monitor: predict on input, check on output ----------------

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    logic [2:0]  f;
    logic [31:0] acc, oy, res, y;
    y_pred_t     p;
    if (rst_n && psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_NUMBER_FORMAT: cur_fmt   <= pwdata[2:0];
        REG_ALPHA:         cur_alpha <= pwdata;
        REG_BETA:          cur_beta  <= pwdata;
        default: ;
      endcase
    end
    if (rst_n && in_valid && !in_stall) begin
      requests_taken <= requests_taken + 1;
      f   = (cur_fmt > FMT_BF16_WIDE) ? FMT_BF16_WIDE : cur_fmt;
      acc = fp_add(dot_acc, fp_mul(widen_element(f, in_matrix_bits),
                                   widen_element(f, in_vector_bits)));
      if (in_end_of_dot) begin
        if (f == FMT_FP16) oy = h16_to_fp32(in_old_y_bits[15:0]);
        else if (f == FMT_BF16) oy = {in_old_y_bits[15:0], 16'b0};
        else oy = in_old_y_bits;
        res = fp_add(fp_mul(cur_alpha, acc), fp_mul(cur_beta, oy));
        if (f == FMT_FP16) y = {16'b0, fp32_to_h16(res)};
        else if (f == FMT_BF16) y = {16'b0, fp32_to_bf16(res)};
        else y = is_nan(res) ? FP32_QNAN : res;
        p.y = y;
        p.known = pending_known;
        p.y_typed = pending_typed;
        y_pending.push_back(p);
        dot_acc <= 32'h0;
      end else begin
        dot_acc <= acc;
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (y_pending.size() == 0) begin
        report_mismatch($sformatf("unexpected y_bits %h", out_y_bits));
      end else begin
        p = y_pending.pop_front();
        if (out_y_bits !== p.y)
          report_mismatch($sformatf("y_bits %h, predicted %h", out_y_bits, p.y));
        if (p.known && out_y_bits !== p.y_typed)
          report_mismatch($sformatf("y_bits %h, known answer %h", out_y_bits, p.y_typed));
      end
    end
  end

  // ---------------- receiver ----------------

  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        long_hold_req = 0;
        out_stall <= 1'b0;
      end else if (n > 0) begin
        n--;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin out_stall <= 1'b0; n = $urandom_range(0, 12); end
          5, 6, 7, 8:    begin out_stall <= 1'b1; n = $urandom_range(0, 3); end
          default:       begin out_stall <= 1'b1; n = $urandom_range(10, 40); end
        endcase
      end
    end
  end

  // ---------------- sender ----------------

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain_results();
    while (y_pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // offer one request and hold it until taken, then maybe idle
  task automatic send_element(input logic [31:0] m, input logic [31:0] v, input logic [31:0] oy,
                              input logic eod, input bit gaps);
    int unsigned taken;
    int          r;
    in_valid <= 1'b1;
    in_matrix_bits <= m; in_vector_bits <= v; in_old_y_bits <= oy; in_end_of_dot <= eod;
    taken = requests_taken;
    do @(negedge clk); while (requests_taken == taken);
    r = $urandom_range(0, 9);
    if (gaps && r >= 6) begin
      in_valid <= 1'b0;
      repeat ((r == 9) ? $urandom_range(10, 40) : $urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_operand(input logic [2:0] f);
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(0, 7) == 0) return r;
    case (f)
      FMT_FP32: return {r[31], 8'($urandom_range(117, 137)), r[22:0]};
      FMT_FP16, FMT_FP16_WIDE: return {r[31:16], r[15], 5'($urandom_range(10, 20)), r[9:0]};
      default: return {r[31:16], r[15], 8'($urandom_range(120, 134)), r[6:0]};
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7F7F_FFFF;
      3: return 32'h3F80_0000;
      4: return $urandom;
      default: return {1'($urandom), 8'($urandom_range(120, 132)), 23'($urandom)};
    endcase
  endfunction

  dot_row_t known_rows[] = '{
    '{32'h3F80_0000, 32'h4000_0000, 32'h0, 1'b1, 1'b1, 32'h4000_0000},
    '{32'h0000_0000, 32'h0000_0000, 32'h0, 1'b1, 1'b1, 32'h0000_0000},
    '{32'h7F80_0000, 32'h0000_0000, 32'h0, 1'b1, 1'b1, FP32_QNAN},
    '{32'h7FC0_0001, 32'h3F80_0000, 32'h0, 1'b1, 1'b1, FP32_QNAN},
    '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0, 1'b1, 1'b1, 32'h7F80_0000},
    '{32'h0000_0001, 32'h3F80_0000, 32'h0, 1'b1, 1'b1, 32'h0000_0001},
    '{32'h8000_0001, 32'h3F80_0000, 32'h0, 1'b1, 1'b1, 32'h8000_0001},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, FP32_QNAN},
    '{32'h3F80_0000, 32'h3F80_0000, 32'h0, 1'b0, 1'b0, 32'h0},
    '{32'h3F80_0000, 32'h3F80_0000, 32'h0, 1'b1, 1'b1, 32'h4000_0000},
    '{32'h7F80_0000, 32'h3F80_0000, 32'h0, 1'b0, 1'b0, 32'h0},
    '{32'hFF80_0000, 32'h3F80_0000, 32'h0, 1'b1, 1'b1, FP32_QNAN},
    '{32'h8000_0000, 32'h0000_0000, 32'h0, 1'b1, 1'b1, 32'h0000_0000},
    '{32'h3F80_0000, 32'h3F80_0000, 32'h7F80_0000, 1'b1, 1'b1, FP32_QNAN},
    '{32'h3F80_0000, 32'h0080_0000, 32'h0, 1'b1, 1'b1, 32'h0080_0000}
  };

  initial begin
    logic [2:0] f;
    int         len;
    bit         gaps;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: fp32, alpha one, beta zero
    foreach (known_rows[i]) begin
      pending_known = known_rows[i].known;
      pending_typed = known_rows[i].y;
      send_element(known_rows[i].m, known_rows[i].v, known_rows[i].oy, known_rows[i].eod, 0);
    end
    in_valid <= 1'b0;
    pending_known = 0;
    drain_results();

    for (int ph = 0; ph < 12; ph++) begin
      f = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 4));
      reg_write(REG_NUMBER_FORMAT, {29'($urandom), f});
      reg_write(REG_ALPHA, (ph == 0) ? 32'hFFFF_FFFF : pick_scale());
      reg_write(REG_BETA, (ph == 1) ? 32'h7F7F_FFFF : pick_scale());
      gaps = (ph % 4 != 3);
      for (int n = 0; n < 83; n += len) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        if (ph == 4 && n == 0) long_hold_req = 1;
        for (int k = 0; k < len; k++)
          send_element(pick_operand(f), pick_operand(f), $urandom, k == len - 1, gaps);
        if (ph == 5 && n == 0) begin
          // pause until the block has returned everything
          in_valid <= 1'b0;
          while (y_pending.size() != 0) @(negedge clk);
        end
      end
      in_valid <= 1'b0;
      drain_results();
    end

    if (mismatches == 0) begin
      $display("gemv_dot_scale_accumulate test passed");
    end else begin
      $display("gemv_dot_scale_accumulate test failed");
    end
    $finish;
  end

endmodule
